// File: hdl/fbpa_pkg.sv
// Shared types, request and status codes, and a helper for the fixed block pool allocator.
package fbpa_pkg;

  localparam int WORD_W  = 32;
  localparam int WORD_BW = 5;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_BAD_FREE = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [9:0] block_index;
  } fbpa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  granted_index;
    logic [15:0] granted_offset;
    logic [10:0] free_count;
  } fbpa_out_t;

  // Result of one request as the sequencer hands it over, with the full block index.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] index;
    logic [10:0] free_count;
  } fbpa_grant_t;

  function automatic logic [WORD_BW-1:0] first_zero(input logic [WORD_W-1:0] w);
    logic [WORD_BW-1:0] pos;
    logic               found;
    pos   = '0;
    found = 1'b0;
    for (int i = 0; i < WORD_W; i++) begin
      if (!found && !w[i]) begin
        pos   = WORD_BW'(i);
        found = 1'b1;
      end
    end
    return pos;
  endfunction

endpackage

// File: hdl/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/fbpa_ctrl.sv
// Request sequencer: bitmap word read, lowest-free search, write-back, count and sweep.
module fbpa_ctrl
  import fbpa_pkg::*;
#(
  parameter int NUM_BLOCKS = 1024,
  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W,
  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fbpa_in_t          in_data,
  output logic              grant_valid,
  input  logic              grant_ready,
  output fbpa_grant_t       grant,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [WORD_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  logic [WORD_W-1:0] ram_rdata
);

  localparam int CW        = $clog2(NUM_BLOCKS + 1);
  localparam int LAST_BITS = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_W;
  localparam logic [63:0] LAST_ONES = (64'd1 << LAST_BITS) - 64'd1;
  localparam logic [WORD_W-1:0] PAD_MASK  = ~LAST_ONES[WORD_W-1:0];
  localparam logic [AW-1:0]     LAST_WORD = AW'(NUM_WORDS - 1);
  localparam logic [CW-1:0]     FULL_CNT  = CW'(NUM_BLOCKS);

  typedef enum logic [4:0] {
    ST_INIT = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_EVAL = 5'b00100,
    ST_CLR  = 5'b01000,
    ST_DONE = 5'b10000
  } fbpa_state_t;

  fbpa_state_t        state_r, state_nxt;
  logic [1:0]         req_r, req_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [WORD_BW-1:0] fbit_r, fbit_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      low_r, low_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [1:0]         st_r, st_nxt;
  logic [15:0]        gidx_r, gidx_nxt;

  logic [31:0]        idx32;
  logic               in_range;
  logic [WORD_W-1:0]  word;
  logic [WORD_BW-1:0] fz;

  assign idx32    = 32'(in_data.block_index);
  assign in_range = idx32 < 32'(NUM_BLOCKS);
  assign word     = ram_rdata | ((addr_r == LAST_WORD) ? PAD_MASK : '0);
  assign fz       = first_zero(word);

  assign grant.status     = st_r;
  assign grant.index      = gidx_r;
  assign grant.free_count = 11'(32'(NUM_BLOCKS) - 32'(cnt_r));

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    addr_nxt    = addr_r;
    fbit_nxt    = fbit_r;
    cnt_nxt     = cnt_r;
    low_nxt     = low_r;
    clr_nxt     = clr_r;
    st_nxt      = st_r;
    gidx_nxt    = gidx_r;
    in_ready    = 1'b0;
    grant_valid = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = addr_r;
    ram_wdata   = word;
    ram_re      = 1'b0;
    ram_raddr   = low_r;
    unique case (state_r) inside
      ST_INIT, ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_WORD) begin
          clr_nxt   = '0;
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_data.req_type;
          st_nxt    = STAT_OK;
          gidx_nxt  = '0;
          state_nxt = ST_DONE;
          case (in_data.req_type)
            REQ_ALLOC: begin
              if (cnt_r == FULL_CNT) begin
                st_nxt = STAT_FULL;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = low_r;
                addr_nxt  = low_r;
                state_nxt = ST_EVAL;
              end
            end
            REQ_FREE: begin
              if (in_range) begin
                ram_re    = 1'b1;
                ram_raddr = idx32[WORD_BW +: AW];
                addr_nxt  = idx32[WORD_BW +: AW];
                fbit_nxt  = idx32[WORD_BW-1:0];
                state_nxt = ST_EVAL;
              end else begin
                st_nxt = STAT_BAD_FREE;
              end
            end
            REQ_CLEAR: begin
              cnt_nxt   = '0;
              low_nxt   = '0;
              clr_nxt   = '0;
              state_nxt = ST_CLR;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_EVAL: begin
        if (req_r == REQ_ALLOC) begin
          if (&word) begin
            addr_nxt  = addr_r + AW'(1);
            low_nxt   = addr_r + AW'(1);
            ram_re    = 1'b1;
            ram_raddr = addr_r + AW'(1);
          end else begin
            ram_we    = 1'b1;
            ram_wdata = word | (WORD_W'(1) << fz);
            cnt_nxt   = cnt_r + CW'(1);
            gidx_nxt  = 16'({addr_r, fz});
            state_nxt = ST_DONE;
          end
        end else begin
          if (word[fbit_r]) begin
            ram_we    = 1'b1;
            ram_wdata = word & ~(WORD_W'(1) << fbit_r);
            cnt_nxt   = cnt_r - CW'(1);
            if (addr_r < low_r) begin
              low_nxt = addr_r;
            end
          end else begin
            st_nxt = STAT_BAD_FREE;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        grant_valid = 1'b1;
        if (grant_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cnt_r   <= '0;
      low_r   <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      low_r   <= low_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    addr_r <= addr_nxt;
    fbit_r <= fbit_nxt;
    st_r   <= st_nxt;
    gidx_r <= gidx_nxt;
  end

endmodule

// File: hdl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: bitmap RAM, sequencer and result register.
//
//   Port group   Direction  Handshake           Beat payload
//   in_*         input      in_valid/in_ready   fbpa_in_t: req_type, block_index
//   out_*        output     out_valid/out_ready fbpa_out_t: status, index, offset, free_count
//
// The used/free marks live in a RAM of 32-bit words; one request is served at a time.
// Allocate reads the word at the lowest-free pointer and steps on past each full word;
// free reads one word and clears one bit, a full pool or out-of-range index needs no read,
// and clear zeroes every word. After reset a sweep zeroes the RAM; in_ready is low meanwhile.
// The result register lets a new request enter while the last result is still waiting.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int NUM_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fbpa_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output fbpa_out_t out_data
);

  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic              grant_valid;
  logic              grant_ready;
  fbpa_grant_t       grant;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic              out_valid_r, out_valid_nxt;
  fbpa_out_t         out_r, out_nxt;
  logic [31:0]       offset;

  fbpa_ctrl #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .grant_valid(grant_valid),
    .grant_ready(grant_ready),
    .grant      (grant),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  fbpa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign grant_ready = !out_valid_r || out_ready;
  assign offset      = 32'(grant.index) * 32'(BLOCK_BYTES);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (grant_valid && grant_ready) begin
      out_valid_nxt          = 1'b1;
      out_nxt.status         = grant.status;
      out_nxt.granted_index  = grant.index[9:0];
      out_nxt.granted_offset = offset[15:0];
      out_nxt.free_count     = grant.free_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
